[rtl/lpfs_pkg.sv]
// shared constants and types for the length-prefixed frame splitter
`timescale 1ns / 1ps
`default_nettype none

package lpfs_pkg;

  localparam int unsigned HEADER_BYTES   = 4;
  localparam int unsigned HDR_CNT_W      = 3;
  localparam int unsigned LEN_W          = 32;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned LEN_WORD_BYTES = LEN_W / BYTE_W;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 32;

  localparam logic [LEN_W-1:0] MAX_FRAME_LENGTH_RST = LEN_W'(65535);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_FRAME_LENGTH  = 1'b0,
    CFG_LENGTH_BIG_ENDIAN = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              in_header;
    logic              frame_first;
    logic              frame_last;
    logic              length_error;
  } result_t;

endpackage

`default_nettype wire

[rtl/lpfs_if.sv]
// stream interfaces for the byte input and the marked byte output
`timescale 1ns / 1ps
`default_nettype none

interface lpfs_in_if import lpfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface lpfs_out_if import lpfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              in_header;
  logic              frame_first;
  logic              frame_last;
  logic              length_error;

  modport source (output valid, output out_byte, output in_header, output frame_first,
                  output frame_last, output length_error, input ready);
  modport sink   (input valid, input out_byte, input in_header, input frame_first,
                  input frame_last, input length_error, output ready);
endinterface

`default_nettype wire

[rtl/lpfs_parser.sv]
// per-byte frame parser: header assembly, length check and payload count
`timescale 1ns / 1ps
`default_nettype none

module lpfs_parser import lpfs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic [LEN_W-1:0]  max_frame_length,
  input  wire logic              length_big_endian,
  output result_t                res
);

  logic [HDR_CNT_W-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [LEN_W-1:0]     partial_r, partial_nxt;
  logic [LEN_W-1:0]     left_r, left_nxt;
  logic                 error_r, error_nxt;
  logic [LEN_W-1:0]     absorbed;
  logic [LEN_W-1:0]     left_dec;
  logic [LEN_W-1:0]     payload_len;
  logic                 hdr_done;
  logic                 len_bad;

  // length word with this byte folded in
  always_comb begin
    absorbed = partial_r;
    if (length_big_endian) begin
      if (partial_r[LEN_W-1 -: BYTE_W] != '0) begin
        absorbed = '1;
      end else begin
        absorbed = {partial_r[LEN_W-BYTE_W-1:0], data_byte};
      end
    end else begin
      if (hdr_cnt_r < HDR_CNT_W'(LEN_WORD_BYTES)) begin
        absorbed = partial_r | (LEN_W'(data_byte) << {hdr_cnt_r[1:0], 3'b000});
      end else if (data_byte != '0) begin
        absorbed = '1;
      end
    end
  end

  assign hdr_done    = (hdr_cnt_r == HDR_CNT_W'(HEADER_BYTES - 1));
  assign len_bad     = (absorbed < LEN_W'(HEADER_BYTES)) || (absorbed > max_frame_length);
  assign payload_len = absorbed - LEN_W'(HEADER_BYTES);
  assign left_dec    = left_r - LEN_W'(1);

  always_comb begin
    hdr_cnt_nxt = hdr_cnt_r;
    partial_nxt = partial_r;
    left_nxt    = left_r;
    error_nxt   = error_r;
    res         = '0;
    priority if (error_r) begin
      res.length_error = 1'b1;
    end else if (left_r != '0) begin
      left_nxt       = left_dec;
      res.out_byte   = data_byte;
      res.frame_last = (left_dec == '0);
    end else if (!hdr_done) begin
      hdr_cnt_nxt     = hdr_cnt_r + HDR_CNT_W'(1);
      partial_nxt     = absorbed;
      res.out_byte    = data_byte;
      res.in_header   = 1'b1;
      res.frame_first = (hdr_cnt_r == '0);
    end else begin
      hdr_cnt_nxt = '0;
      partial_nxt = '0;
      if (len_bad) begin
        error_nxt        = 1'b1;
        res.length_error = 1'b1;
      end else begin
        left_nxt        = payload_len;
        res.out_byte    = data_byte;
        res.in_header   = 1'b1;
        res.frame_first = (hdr_cnt_r == '0);
        res.frame_last  = (payload_len == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r <= '0;
      partial_r <= '0;
      left_r    <= '0;
      error_r   <= 1'b0;
    end else if (take) begin
      hdr_cnt_r <= hdr_cnt_nxt;
      partial_r <= partial_nxt;
      left_r    <= left_nxt;
      error_r   <= error_nxt;
    end
  end

`ifndef SYNTHESIS
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    error_r |=> error_r)
    else $error("error flag cleared without reset");

  a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_cnt_r < HDR_CNT_W'(HEADER_BYTES))
    else $error("header byte count out of range");

  a_payload_no_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (left_r != '0) |-> (hdr_cnt_r == '0 && partial_r == '0))
    else $error("header state not clear during payload");

  a_err_discards: assert property (@(posedge clk) disable iff (!rst_n)
    (take && error_r) |-> (res.out_byte == '0 && !res.in_header && !res.frame_first
                           && !res.frame_last && res.length_error))
    else $error("byte not discarded after length error");
`endif

endmodule

`default_nettype wire

[rtl/length_prefixed_frame_splitter.sv]
// top level of the length-prefixed frame splitter
`timescale 1ns / 1ps
`default_nettype none

// Takes one byte per transfer and returns one marked byte per transfer. Each
// frame opens with a 4-byte length word (little or big endian, set by
// length_big_endian) that counts the whole frame, header included; output
// bytes carry in_header, frame_first and frame_last. A length below 4 or
// above max_frame_length sets length_error, which stays set and turns every
// later byte into a discarded result, all zero but length_error, until
// reset. Throughput is one byte per clock while out_stream.ready is high:
// the parser state updates in the cycle a byte is taken and the result sits
// in a single output register, which is refilled in the same cycle it is
// taken. Configuration writes are meant for idle periods only.

module length_prefixed_frame_splitter import lpfs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  lpfs_in_if.sink                    in_stream,
  lpfs_out_if.source                 out_stream,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [LEN_W-1:0] max_len_r;
  logic             big_endian_r;
  logic             out_valid_r;
  result_t          res_r;
  result_t          res;
  logic             take;

  assign in_stream.ready = !out_valid_r || out_stream.ready;
  assign take            = in_stream.valid && in_stream.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r    <= MAX_FRAME_LENGTH_RST;
      big_endian_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MAX_FRAME_LENGTH:  max_len_r    <= cfg_wdata[LEN_W-1:0];
        CFG_LENGTH_BIG_ENDIAN: big_endian_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  lpfs_parser u_parser (
    .clk               (clk),
    .rst_n             (rst_n),
    .take              (take),
    .data_byte         (in_stream.data_byte),
    .max_frame_length  (max_len_r),
    .length_big_endian (big_endian_r),
    .res               (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_stream.ready) begin
      out_valid_r <= in_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

  assign out_stream.valid        = out_valid_r;
  assign out_stream.out_byte     = res_r.out_byte;
  assign out_stream.in_header    = res_r.in_header;
  assign out_stream.frame_first  = res_r.frame_first;
  assign out_stream.frame_last   = res_r.frame_last;
  assign out_stream.length_error = res_r.length_error;

endmodule

`default_nettype wire
